// ===== rtl/rfbs_pkg.sv =====
// ============================================================================
// rfbs_pkg: shared constants and helpers for the RF filter band selector
// Band edge tables in kHz, alphabetical search order, field widths and the
// stage-advance bundle passed from the top level to the band search.
// ============================================================================
package rfbs_pkg;

    localparam int INDEX_STEPS_DEF = 15;
    localparam int FREQ_BITS_DEF   = 24;

    localparam int BAND_COUNT      = 12;
    localparam int FILTERED_COUNT  = BAND_COUNT - 1;
    localparam int CODE_BITS       = 4;
    localparam int CHOICE_BITS     = 4;
    localparam int OUT_FREQ_BITS   = 24;
    // largest band edge is 7200000 kHz
    localparam int EDGE_BITS       = 23;
    // smallest band width is 15000 kHz, so twice it is at least 2**14
    localparam int MIN_DEN2_LOG    = 14;

    localparam logic [CODE_BITS-1:0]   BYPASS_CODE = CODE_BITS'(11);
    localparam logic [CHOICE_BITS-1:0] AUTO_CHOICE = CHOICE_BITS'(12);

    localparam logic [EDGE_BITS-1:0] BAND_LO [BAND_COUNT] = '{
        EDGE_BITS'(1880000), EDGE_BITS'(2010000), EDGE_BITS'(2300000),
        EDGE_BITS'(2496000), EDGE_BITS'(2570000), EDGE_BITS'(3300000),
        EDGE_BITS'(3550000), EDGE_BITS'(3300000), EDGE_BITS'(4400000),
        EDGE_BITS'(5150000), EDGE_BITS'(5925000), EDGE_BITS'(350000)
    };

    localparam logic [EDGE_BITS-1:0] BAND_HI [BAND_COUNT] = '{
        EDGE_BITS'(1920000), EDGE_BITS'(2025000), EDGE_BITS'(2400000),
        EDGE_BITS'(2690000), EDGE_BITS'(2620000), EDGE_BITS'(3800000),
        EDGE_BITS'(3700000), EDGE_BITS'(4200000), EDGE_BITS'(5000000),
        EDGE_BITS'(5925000), EDGE_BITS'(7125000), EDGE_BITS'(7200000)
    };

    // filtered band codes sorted by band name
    localparam logic [CODE_BITS-1:0] ALPHA_ORDER [FILTERED_COUNT] = '{
        CODE_BITS'(1), CODE_BITS'(4), CODE_BITS'(0), CODE_BITS'(2),
        CODE_BITS'(3), CODE_BITS'(9), CODE_BITS'(6), CODE_BITS'(7),
        CODE_BITS'(5), CODE_BITS'(8), CODE_BITS'(10)
    };

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } rfbs_adv_t;

    function automatic logic [EDGE_BITS-1:0] band_lo(input logic [CODE_BITS-1:0] code);
        logic [EDGE_BITS-1:0] v;
        if (code < CODE_BITS'(BAND_COUNT))
            v = BAND_LO[code];
        else
            v = BAND_LO[BYPASS_CODE];
        return v;
    endfunction

    function automatic logic [EDGE_BITS-1:0] band_hi(input logic [CODE_BITS-1:0] code);
        logic [EDGE_BITS-1:0] v;
        if (code < CODE_BITS'(BAND_COUNT))
            v = BAND_HI[code];
        else
            v = BAND_HI[BYPASS_CODE];
        return v;
    endfunction

endpackage

// ===== rtl/rfbs_nearest.sv =====
// ============================================================================
// rfbs_nearest: automatic band search
// Three stages: containment and midpoint distance per band, best of each
// group of four in name order, then best overall (bypass when none fits).
// ============================================================================
module rfbs_nearest #(
    parameter int FREQ_BITS = rfbs_pkg::FREQ_BITS_DEF
) (
    input  logic                           clk,
    input  rfbs_pkg::rfbs_adv_t            adv,
    input  logic [FREQ_BITS-1:0]           freq,
    output logic [rfbs_pkg::CODE_BITS-1:0] pick_code
);

    localparam int NB         = rfbs_pkg::FILTERED_COUNT;
    localparam int DIST_BITS  = rfbs_pkg::EDGE_BITS + 1;
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = (NB + GROUP_SIZE - 1) / GROUP_SIZE;

    // stage 1: per band, in name order
    logic [NB-1:0]        hit_next;
    logic [NB-1:0]        hit_reg;
    logic [DIST_BITS-1:0] dist_next [NB];
    logic [DIST_BITS-1:0] dist_reg  [NB];

    logic [DIST_BITS-1:0] freq2;
    assign freq2 = {freq[rfbs_pkg::EDGE_BITS-1:0], 1'b0};

    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_band
            localparam logic [rfbs_pkg::CODE_BITS-1:0] CODE = rfbs_pkg::ALPHA_ORDER[k];
            localparam logic [DIST_BITS-1:0] MID2 =
                DIST_BITS'(rfbs_pkg::BAND_LO[CODE]) + DIST_BITS'(rfbs_pkg::BAND_HI[CODE]);

            assign hit_next[k] = (FREQ_BITS'(rfbs_pkg::BAND_LO[CODE]) <= freq)
                              && (freq <= FREQ_BITS'(rfbs_pkg::BAND_HI[CODE]));
            assign dist_next[k] = (MID2 > freq2) ? (MID2 - freq2) : (freq2 - MID2);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    // stage 2: best within each group, strict less keeps the earlier name
    logic [NUM_GROUPS-1:0]        grp_found_next;
    logic [NUM_GROUPS-1:0]        grp_found_reg;
    logic [DIST_BITS-1:0]         grp_dist_next [NUM_GROUPS];
    logic [DIST_BITS-1:0]         grp_dist_reg  [NUM_GROUPS];
    logic [rfbs_pkg::CODE_BITS-1:0] grp_code_next [NUM_GROUPS];
    logic [rfbs_pkg::CODE_BITS-1:0] grp_code_reg  [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_found_next[g] = 1'b0;
            grp_dist_next[g]  = '0;
            grp_code_next[g]  = rfbs_pkg::BYPASS_CODE;
            for (int j = 0; j < GROUP_SIZE && g * GROUP_SIZE + j < NB; j++)
            begin
                if (hit_reg[g * GROUP_SIZE + j] && (!grp_found_next[g]
                    || dist_reg[g * GROUP_SIZE + j] < grp_dist_next[g]))
                begin
                    grp_found_next[g] = 1'b1;
                    grp_dist_next[g]  = dist_reg[g * GROUP_SIZE + j];
                    grp_code_next[g]  = rfbs_pkg::ALPHA_ORDER[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            grp_found_reg <= grp_found_next;
            grp_dist_reg  <= grp_dist_next;
            grp_code_reg  <= grp_code_next;
        end
    end

    // stage 3: merge groups in name order
    logic                           best_found;
    logic [DIST_BITS-1:0]           best_dist;
    logic [rfbs_pkg::CODE_BITS-1:0] best_code;
    logic [rfbs_pkg::CODE_BITS-1:0] pick_reg;

    always_comb
    begin
        best_found = 1'b0;
        best_dist  = '0;
        best_code  = rfbs_pkg::BYPASS_CODE;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (grp_found_reg[g] && (!best_found || grp_dist_reg[g] < best_dist))
            begin
                best_found = 1'b1;
                best_dist  = grp_dist_reg[g];
                best_code  = grp_code_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
            pick_reg <= best_code;
    end

    assign pick_code = pick_reg;

endmodule

// ===== rtl/rf_filter_band_select_unit.sv =====
// ============================================================================
// rf_filter_band_select_unit: RF filter band selector
// Maps a tune frequency and band choice to a filter band, clamped frequency
// and rounded position index within the band.
// ============================================================================
// Fully pipelined: one request per cycle sustained while the output is
// not stalled. Stages 1-3 run the automatic band search, stage 4 clamps
// and forms the index numerator, stages 5-7 divide it by the band
// width through a reciprocal multiply, a back-multiply and one correction
// step. Per-stage valid bits with a ready chain let bubbles close up under
// output backpressure, so the input keeps taking requests until every stage
// is full.
module rf_filter_band_select_unit #(
    parameter int INDEX_STEPS = rfbs_pkg::INDEX_STEPS_DEF,
    parameter int FREQ_BITS   = rfbs_pkg::FREQ_BITS_DEF,
    localparam int STEP_BITS  = $clog2(INDEX_STEPS + 1),
    localparam int IN_BITS    = FREQ_BITS + rfbs_pkg::CHOICE_BITS,
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = rfbs_pkg::CODE_BITS + STEP_BITS + rfbs_pkg::OUT_FREQ_BITS,
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // tune_khz, band_choice
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // band_code, step_index, clamped_khz
    output logic                      m_tuser    // bad_choice
);

    localparam int EB      = rfbs_pkg::EDGE_BITS;
    localparam int CB      = rfbs_pkg::CODE_BITS;
    localparam int HB      = rfbs_pkg::CHOICE_BITS;
    localparam int D2_BITS = EB + 1;
    localparam int X_BITS  = $clog2(2 * INDEX_STEPS + 1) + EB;
    localparam int R_BITS  = X_BITS - rfbs_pkg::MIN_DEN2_LOG;
    localparam int P_BITS  = X_BITS + R_BITS;
    localparam int QD_BITS = STEP_BITS + D2_BITS;
    localparam int W_BITS  = X_BITS + QD_BITS;
    localparam int NSTAGE  = 7;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE+1:1] ready;

    always_comb
    begin
        ready[NSTAGE+1] = m_tready;
        for (int i = NSTAGE; i >= 1; i--)
            ready[i] = !valid_reg[i] || ready[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ready[1])
                valid_reg[1] <= s_tvalid;
            for (int i = 2; i <= NSTAGE; i++)
                if (ready[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign s_tready = ready[1];
    assign m_tvalid = valid_reg[NSTAGE];

    // ------------------------------------------------------------------
    // stages 1-3: automatic band search, request fields carried alongside
    // ------------------------------------------------------------------
    logic [FREQ_BITS-1:0] in_freq;
    logic [HB-1:0]        in_choice;
    assign in_freq   = s_tdata[FREQ_BITS-1:0];
    assign in_choice = s_tdata[FREQ_BITS +: HB];

    rfbs_pkg::rfbs_adv_t  adv;
    logic [CB-1:0]        pick_code;

    assign adv = '{s1: ready[1], s2: ready[2], s3: ready[3]};

    rfbs_nearest #(
        .FREQ_BITS (FREQ_BITS)
    ) u_nearest (
        .clk       (clk),
        .adv       (adv),
        .freq      (in_freq),
        .pick_code (pick_code)
    );

    logic [FREQ_BITS-1:0] s1_freq_reg, s2_freq_reg, s3_freq_reg;
    logic [HB-1:0]        s1_choice_reg, s2_choice_reg, s3_choice_reg;

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            s1_freq_reg   <= in_freq;
            s1_choice_reg <= in_choice;
        end
        if (ready[2])
        begin
            s2_freq_reg   <= s1_freq_reg;
            s2_choice_reg <= s1_choice_reg;
        end
        if (ready[3])
        begin
            s3_freq_reg   <= s2_freq_reg;
            s3_choice_reg <= s2_choice_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: band select, clamp, index numerator X = 2*N*(f-lo) + den
    // ------------------------------------------------------------------
    logic          s4_bad_next;
    logic [CB-1:0] s4_code_next;
    logic [EB-1:0] lo, hi, den;
    logic [EB-1:0] s4_fc_next;
    logic [X_BITS-1:0]  s4_x_next;

    always_comb
    begin
        s4_bad_next = s3_choice_reg > rfbs_pkg::AUTO_CHOICE;
        if (s4_bad_next)
            s4_code_next = rfbs_pkg::BYPASS_CODE;
        else if (s3_choice_reg == rfbs_pkg::AUTO_CHOICE)
            s4_code_next = pick_code;
        else
            s4_code_next = CB'(s3_choice_reg);

        lo  = rfbs_pkg::band_lo(s4_code_next);
        hi  = rfbs_pkg::band_hi(s4_code_next);
        den = hi - lo;

        priority if (s3_freq_reg < FREQ_BITS'(lo))
            s4_fc_next = lo;
        else if (s3_freq_reg > FREQ_BITS'(hi))
            s4_fc_next = hi;
        else
            s4_fc_next = s3_freq_reg[EB-1:0];

        s4_x_next = X_BITS'(2 * INDEX_STEPS) * X_BITS'(s4_fc_next - lo) + X_BITS'(den);
    end

    logic               s4_bad_reg, s5_bad_reg, s6_bad_reg;
    logic [CB-1:0]      s4_code_reg, s5_code_reg, s6_code_reg;
    logic [EB-1:0]      s4_fc_reg, s5_fc_reg, s6_fc_reg;
    logic [X_BITS-1:0]  s4_x_reg, s5_x_reg, s6_x_reg;
    logic [D2_BITS-1:0] s4_d2_reg, s5_d2_reg, s6_d2_reg;

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            s4_bad_reg  <= s4_bad_next;
            s4_code_reg <= s4_code_next;
            s4_fc_reg   <= s4_fc_next;
            s4_x_reg    <= s4_x_next;
            s4_d2_reg   <= {den, 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // stage 5: quotient estimate floor(X * floor(2^X_BITS / 2den) / 2^X_BITS)
    // estimate is exact or one low since X < 2^X_BITS
    // ------------------------------------------------------------------
    logic [R_BITS-1:0] recip [rfbs_pkg::BAND_COUNT];

    genvar g;
    generate
        for (g = 0; g < rfbs_pkg::BAND_COUNT; g++)
        begin : g_recip
            localparam logic [63:0] RECIP_FULL = (64'd1 << X_BITS)
                / (64'd2 * 64'(rfbs_pkg::BAND_HI[g] - rfbs_pkg::BAND_LO[g]));
            assign recip[g] = RECIP_FULL[R_BITS-1:0];
        end
    endgenerate

    logic [P_BITS-1:0]    prod;
    logic [STEP_BITS-1:0] s5_q_reg, s6_q_reg;

    assign prod = P_BITS'(s4_x_reg) * P_BITS'(recip[s4_code_reg]);

    always_ff @(posedge clk)
    begin
        if (ready[5])
        begin
            s5_q_reg    <= STEP_BITS'(prod >> X_BITS);
            s5_bad_reg  <= s4_bad_reg;
            s5_code_reg <= s4_code_reg;
            s5_fc_reg   <= s4_fc_reg;
            s5_x_reg    <= s4_x_reg;
            s5_d2_reg   <= s4_d2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: back-multiply q * 2den
    // ------------------------------------------------------------------
    logic [QD_BITS-1:0] s6_qd_reg;

    always_ff @(posedge clk)
    begin
        if (ready[6])
        begin
            s6_qd_reg   <= QD_BITS'(s5_q_reg) * QD_BITS'(s5_d2_reg);
            s6_q_reg    <= s5_q_reg;
            s6_bad_reg  <= s5_bad_reg;
            s6_code_reg <= s5_code_reg;
            s6_fc_reg   <= s5_fc_reg;
            s6_x_reg    <= s5_x_reg;
            s6_d2_reg   <= s5_d2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: one correction step, hold to range, output register
    // ------------------------------------------------------------------
    logic [W_BITS-1:0]    rem;
    logic [STEP_BITS:0]   q_fix;
    logic [STEP_BITS-1:0] step_next;

    always_comb
    begin
        rem   = W_BITS'(s6_x_reg) - W_BITS'(s6_qd_reg);
        q_fix = (STEP_BITS+1)'(s6_q_reg)
              + (STEP_BITS+1)'(rem >= W_BITS'(s6_d2_reg));
        if (q_fix > (STEP_BITS+1)'(INDEX_STEPS))
            step_next = STEP_BITS'(INDEX_STEPS);
        else
            step_next = q_fix[STEP_BITS-1:0];
    end

    logic                             out_bad_reg;
    logic [CB-1:0]                    out_code_reg;
    logic [STEP_BITS-1:0]             out_step_reg;
    logic [rfbs_pkg::OUT_FREQ_BITS-1:0] out_freq_reg;

    always_ff @(posedge clk)
    begin
        if (ready[7])
        begin
            out_bad_reg <= s6_bad_reg;
            if (s6_bad_reg)
            begin
                out_code_reg <= '0;
                out_step_reg <= '0;
                out_freq_reg <= '0;
            end
            else
            begin
                out_code_reg <= s6_code_reg;
                out_step_reg <= step_next;
                out_freq_reg <= rfbs_pkg::OUT_FREQ_BITS'(s6_fc_reg);
            end
        end
    end

    assign m_tdata = OUT_TDATA_BITS'({out_freq_reg, out_step_reg, out_code_reg});
    assign m_tuser = out_bad_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic [CB-1:0]                      chk_code;
    logic [STEP_BITS-1:0]               chk_step;
    logic [rfbs_pkg::OUT_FREQ_BITS-1:0] chk_freq;

    assign chk_code = m_tdata[CB-1:0];
    assign chk_step = m_tdata[CB +: STEP_BITS];
    assign chk_freq = m_tdata[CB + STEP_BITS +: rfbs_pkg::OUT_FREQ_BITS];

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("bad choice result carries nonzero fields");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            chk_code <= rfbs_pkg::BYPASS_CODE
            && chk_step <= STEP_BITS'(INDEX_STEPS))
        else $error("band code or step index out of range");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            chk_freq >= rfbs_pkg::OUT_FREQ_BITS'(rfbs_pkg::band_lo(chk_code))
            && chk_freq <= rfbs_pkg::OUT_FREQ_BITS'(rfbs_pkg::band_hi(chk_code)))
        else $error("clamped frequency outside selected band");

    a_edge_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser
            && chk_freq == rfbs_pkg::OUT_FREQ_BITS'(rfbs_pkg::band_lo(chk_code))
            |-> chk_step == '0)
        else $error("lower band edge gives nonzero step index");

endmodule

// ===== tb/rf_filter_band_select_unit_test.sv =====
// ============================================================================
// rf_filter_band_select_unit_test: band selector stream testbench
// Sends tune requests through the input stream and predicts the band, clamped
// frequency, step index and bad-choice flag of each one. Every response is
// checked in order against the prediction. Both sides stall at random, and
// the run includes long output stalls and a full drain before some requests.
// ============================================================================
module rf_filter_band_select_unit_test;

    localparam int FREQ_W       = 24;
    localparam int STEP_W       = 4;
    localparam int NUM_STEPS    = 15;
    localparam int IN_W         = 32;
    localparam int OUT_W        = 32;
    localparam int MAX_WAIT     = 11;
    localparam int LONG_HOLD    = 60;
    localparam int RANDOM_COUNT = 1900;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [3:0] BAND_N39    = 4'd0;
    localparam logic [3:0] BAND_N34    = 4'd1;
    localparam logic [3:0] BAND_N40    = 4'd2;
    localparam logic [3:0] BAND_N41    = 4'd3;
    localparam logic [3:0] BAND_N38    = 4'd4;
    localparam logic [3:0] BAND_N78    = 4'd5;
    localparam logic [3:0] BAND_N48    = 4'd6;
    localparam logic [3:0] BAND_N77    = 4'd7;
    localparam logic [3:0] BAND_N79    = 4'd8;
    localparam logic [3:0] BAND_N46    = 4'd9;
    localparam logic [3:0] BAND_N96    = 4'd10;
    localparam logic [3:0] BAND_BYPASS = rfbs_pkg::BYPASS_CODE;
    localparam logic [3:0] CHOICE_AUTO = rfbs_pkg::AUTO_CHOICE;
    localparam logic [3:0] BAD_CHOICE_LO = CHOICE_AUTO + 4'd1;
    localparam logic [3:0] BAD_CHOICE_HI = 4'd15;

    // search order for auto mode, first entry in the low nibble
    localparam logic [43:0] NAME_ORDER = {
        BAND_N96, BAND_N79, BAND_N78, BAND_N77, BAND_N48, BAND_N46,
        BAND_N41, BAND_N40, BAND_N39, BAND_N38, BAND_N34
    };

    typedef struct packed {
        logic [3:0]        code;
        logic [STEP_W-1:0] step;
        logic [FREQ_W-1:0] khz;
        logic              bad;
    } band_result_t;

    typedef struct {
        logic [FREQ_W-1:0] tune;
        logic [3:0]        choice;
        bit                drain_first;
    } tune_request_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    tune_request_t pending_q[$];
    band_result_t  expect_q[$];
    tune_request_t next_req;
    band_result_t  want;

    int  tx_gap = 0;
    bit  tx_calm = 1'b0;
    int  rx_hold = 0;
    bit  rx_calm = 1'b0;
    int  rx_count = 0;
    int  idle_cycles = 0;
    int  errors = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  auto_sent = 0;
    int  bad_sent = 0;

    rf_filter_band_select_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void add_request(input tune_request_t r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic void add_expected(input band_result_t r);
        expect_q.insert(expect_q.size(), r);
    endfunction

    function automatic void band_edges(input logic [3:0] code, output longint unsigned lo,
                                       output longint unsigned hi);
        case (code)
            BAND_N39: {lo, hi} = {64'd1880000, 64'd1920000};
            BAND_N34: {lo, hi} = {64'd2010000, 64'd2025000};
            BAND_N40: {lo, hi} = {64'd2300000, 64'd2400000};
            BAND_N41: {lo, hi} = {64'd2496000, 64'd2690000};
            BAND_N38: {lo, hi} = {64'd2570000, 64'd2620000};
            BAND_N78: {lo, hi} = {64'd3300000, 64'd3800000};
            BAND_N48: {lo, hi} = {64'd3550000, 64'd3700000};
            BAND_N77: {lo, hi} = {64'd3300000, 64'd4200000};
            BAND_N79: {lo, hi} = {64'd4400000, 64'd5000000};
            BAND_N46: {lo, hi} = {64'd5150000, 64'd5925000};
            BAND_N96: {lo, hi} = {64'd5925000, 64'd7125000};
            default:  {lo, hi} = {64'd350000, 64'd7200000};
        endcase
    endfunction

    function automatic band_result_t predict_band(input logic [FREQ_W-1:0] tune,
                                                  input logic [3:0] choice);
        band_result_t     r;
        longint unsigned  f, lo, hi, d, best_d, num, den, idx;
        logic [3:0]       code, cand;
        bit               found;
        r = '0;
        if (choice > CHOICE_AUTO)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            f = tune;
            code = choice;
            if (choice == CHOICE_AUTO)
            begin
                code = BAND_BYPASS;
                found = 1'b0;
                best_d = 0;
                for (int k = 0; k < 11; k++)
                begin
                    cand = NAME_ORDER[k*4 +: 4];
                    band_edges(cand, lo, hi);
                    if (lo <= f && f <= hi)
                    begin
                        // doubled distance to the band center
                        d = (lo + hi > 2 * f) ? lo + hi - 2 * f : 2 * f - lo - hi;
                        if (!found || d < best_d)
                        begin
                            found = 1'b1;
                            code = cand;
                            best_d = d;
                        end
                    end
                end
            end
            band_edges(code, lo, hi);
            if (f < lo)
                f = lo;
            if (f > hi)
                f = hi;
            den = hi - lo;
            num = NUM_STEPS * (f - lo);
            idx = (2 * num + den) / (2 * den);
            if (idx > NUM_STEPS)
                idx = NUM_STEPS;
            r.code = code;
            r.step = idx[STEP_W-1:0];
            r.khz = f[FREQ_W-1:0];
        end
        return r;
    endfunction

    function automatic tune_request_t random_request(input bit drain_first);
        tune_request_t   q;
        longint unsigned lo, hi, base;
        int              pick;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
        begin
            q.tune = FREQ_W'($urandom);
        end
        else if (pick <= 5)
        begin
            q.tune = FREQ_W'($urandom_range(300000, 7300000));
        end
        else
        begin
            band_edges(4'($urandom_range(0, 11)), lo, hi);
            if (pick == 9)
                base = (lo + hi) / 2;
            else
                base = $urandom_range(0, 1) ? hi : lo;
            q.tune = FREQ_W'(base + $urandom_range(0, 6) - 3);
        end
        pick = $urandom_range(0, 19);
        if (pick <= 7)
            q.choice = CHOICE_AUTO;
        else if (pick <= 16)
            q.choice = 4'($urandom_range(0, 11));
        else
            q.choice = 4'($urandom_range(BAD_CHOICE_LO, BAD_CHOICE_HI));
        q.drain_first = drain_first;
        return q;
    endfunction

    function automatic tune_request_t fixed_request(input logic [FREQ_W-1:0] tune,
                                                    input logic [3:0] choice);
        tune_request_t q;
        q.tune = tune;
        q.choice = choice;
        q.drain_first = 1'b0;
        return q;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            tx_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                add_expected(predict_band(s_tdata[FREQ_W-1:0], s_tdata[FREQ_W +: 4]));
                requests_sent++;
                if (s_tdata[FREQ_W +: 4] == CHOICE_AUTO)
                    auto_sent++;
                else if (s_tdata[FREQ_W +: 4] > CHOICE_AUTO)
                    bad_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap != 0 && rx_hold <= MAX_WAIT)
                begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0
                         && !(pending_q[0].drain_first && expect_q.size() != 0))
                begin
                    next_req = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_W - FREQ_W - 4){1'b0}}, next_req.choice, next_req.tune};
                    if (tx_calm || rx_hold > MAX_WAIT)
                        tx_gap <= 0;
                    else
                        tx_gap <= $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 63) == 0)
                        tx_calm <= !tx_calm;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // response sink with random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold <= 0;
        end
        else if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end
        else if (m_tvalid && m_tready)
        begin
            rx_count++;
            if (rx_count % 1000 == 300)
            begin
                rx_hold <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                if (!rx_calm && $urandom_range(0, 1) == 1)
                begin
                    rx_hold <= $urandom_range(1, MAX_WAIT);
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
                if ($urandom_range(0, 63) == 0)
                    rx_calm <= !rx_calm;
            end
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expect_q.size() == 0)
            begin
                $display("%0t: unexpected response: code=%0d step=%0d khz=%0d bad=%0b",
                         $time, m_tdata[3:0], m_tdata[7:4], m_tdata[31:8], m_tuser);
                errors++;
            end
            else
            begin
                want = expect_q.pop_front();
                results_checked++;
                if (m_tdata[3:0] !== want.code)
                begin
                    $display("%0t: band_code expected %0d actual %0d",
                             $time, want.code, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[7:4] !== want.step)
                begin
                    $display("%0t: step_index expected %0d actual %0d",
                             $time, want.step, m_tdata[7:4]);
                    errors++;
                end
                if (m_tdata[31:8] !== want.khz)
                begin
                    $display("%0t: clamped_khz expected %0d actual %0d",
                             $time, want.khz, m_tdata[31:8]);
                    errors++;
                end
                if (m_tuser !== want.bad)
                begin
                    $display("%0t: bad_choice expected %0b actual %0b",
                             $time, want.bad, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        add_request(fixed_request(24'd0, BAND_N39));
        add_request(fixed_request(24'hFFFFFF, BAND_N34));
        add_request(fixed_request(24'd2350000, BAND_N40));
        add_request(fixed_request(24'd2593000, BAND_N41));
        add_request(fixed_request(24'd2570000, BAND_N38));
        add_request(fixed_request(24'd3800000, BAND_N78));
        add_request(fixed_request(24'd3625000, BAND_N48));
        add_request(fixed_request(24'd0, BAND_N77));
        add_request(fixed_request(24'd4700000, BAND_N79));
        add_request(fixed_request(24'd5925000, BAND_N46));
        add_request(fixed_request(24'd6000000, BAND_N96));
        add_request(fixed_request(24'd350000, BAND_BYPASS));
        add_request(fixed_request(24'hFFFFFF, BAND_BYPASS));
        // auto: equal distance ties, shared edge, gaps, extremes
        add_request(fixed_request(24'd2594000, CHOICE_AUTO));
        add_request(fixed_request(24'd3587500, CHOICE_AUTO));
        add_request(fixed_request(24'd3687500, CHOICE_AUTO));
        add_request(fixed_request(24'd5925000, CHOICE_AUTO));
        add_request(fixed_request(24'd4300000, CHOICE_AUTO));
        add_request(fixed_request(24'd0, CHOICE_AUTO));
        add_request(fixed_request(24'hFFFFFF, CHOICE_AUTO));
        add_request(fixed_request(24'd1880000, CHOICE_AUTO));
        add_request(fixed_request(24'd7125000, CHOICE_AUTO));
        add_request(fixed_request(24'd123456, BAD_CHOICE_LO));
        add_request(fixed_request(24'hFFFFFF, BAD_CHOICE_LO + 4'd1));
        add_request(fixed_request(24'd0, BAD_CHOICE_HI));
        for (int i = 0; i < RANDOM_COUNT; i++)
            add_request(random_request(i % 600 == 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests (%0d auto, %0d bad choice), checked %0d responses",
                 requests_sent, auto_sent, bad_sent, results_checked);
        $display("with random stalls on both sides, long output backpressure and drains.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rfbs_pkg.sv
rtl/rfbs_nearest.sv
rtl/rf_filter_band_select_unit.sv
tb/rf_filter_band_select_unit_test.sv
